// ===== rtl/core/hpd_pkg.sv =====
package hpd_pkg;

    // Number of motors served by the block and the width of a motor index.
    localparam int NUM_MOTORS  = 2;
    localparam int MOTOR_IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    // Field widths.
    localparam int POS_W    = 16;
    localparam int TIME_W   = 32;
    localparam int SETTLE_W = 8;
    localparam int CMP_W    = POS_W + 2;

    // Stream widths.
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 24;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_HYSTERESIS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_POINT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_OPEN = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TIME  = 2'd3;

    // Register values after reset.
    localparam logic [POS_W-1:0]    RST_HYSTERESIS   = 16'd50;
    localparam logic [POS_W-1:0]    RST_ZERO_POINT   = 16'd0;
    localparam logic [POS_W-1:0]    RST_DEFAULT_OPEN = 16'd50000;
    localparam logic [SETTLE_W-1:0] RST_SETTLE_TIME  = 8'd30;

    // Operating modes.
    localparam logic [2:0] MODE_RUN        = 3'd0;
    localparam logic [2:0] MODE_LEARN      = 3'd1;
    localparam logic [2:0] MODE_JACK_SET_A = 3'd2;
    localparam logic [2:0] MODE_JACK_SET_B = 3'd3;
    localparam logic [2:0] MODE_JACK_SET_C = 3'd4;

    // Setting status codes.
    localparam logic [1:0] STATUS_COMPLETED = 2'd0;
    localparam logic [1:0] STATUS_JACK_UP   = 2'd1;

    // Drive codes: bit 0 is the up pin, bit 1 the down pin.
    localparam logic [1:0] DRIVE_STOP = 2'b00;
    localparam logic [1:0] DRIVE_UP   = 2'b01;
    localparam logic [1:0] DRIVE_DOWN = 2'b10;

    typedef struct packed {
        logic              motor_id;
        logic [2:0]        mode;
        logic [1:0]        setting_status;
        logic              down_request;
        logic              up_request;
        logic [POS_W-1:0]  motor_position;
        logic [POS_W-1:0]  jack_position;
        logic [POS_W-1:0]  jack_top_limit;
        logic [TIME_W-1:0] time_tenths;
    } item_t;

    typedef struct packed {
        logic [POS_W-1:0]    hysteresis;
        logic [POS_W-1:0]    zero_pos;
        logic [POS_W-1:0]    default_open;
        logic [SETTLE_W-1:0] settle_time;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        drive;
        logic [POS_W-1:0]  open_lim;
        logic [POS_W-1:0]  close_lim;
        logic              settle_armed;
        logic [TIME_W-1:0] settle_start;
        logic [POS_W-1:0]  stall_ref;
    } motor_state_t;

    typedef struct packed {
        logic             drive_up;
        logic             drive_down;
        logic             completed_write;
        logic             completed_value;
        logic             zero_position_request;
        logic             return_to_running;
        logic [POS_W-1:0] open_limit_now;
    } result_t;

    // Sign-safe widening of an unsigned position.
    function automatic logic signed [CMP_W-1:0] widen(input logic [POS_W-1:0] v);
        widen = signed'({2'b00, v});
    endfunction

    // True when a value lies strictly inside center +- half width.
    function automatic logic in_band(input logic [POS_W-1:0] v,
                                     input logic [POS_W-1:0] center,
                                     input logic [POS_W-1:0] half);
        logic signed [CMP_W-1:0] lo;
        logic signed [CMP_W-1:0] hi;
        lo = widen(center) - widen(half);
        hi = widen(center) + widen(half);
        in_band = (widen(v) > lo) && (widen(v) < hi);
    endfunction

    // Drive toward a target and stop inside the dead band.
    function automatic logic [1:0] steer(input logic [POS_W-1:0] pos,
                                         input logic [POS_W-1:0] target,
                                         input logic [POS_W-1:0] half);
        logic signed [CMP_W-1:0] lo;
        logic signed [CMP_W-1:0] hi;
        lo = widen(target) - widen(half);
        hi = widen(target) + widen(half);
        if (widen(pos) < lo) begin
            steer = DRIVE_UP;
        end
        else if (widen(pos) > hi) begin
            steer = DRIVE_DOWN;
        end
        else begin
            steer = DRIVE_STOP;
        end
    endfunction

endpackage

// ===== rtl/core/hpd_state.sv =====
module hpd_state (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [hpd_pkg::MOTOR_IDX_W-1:0]   rd_index,
    output hpd_pkg::motor_state_t             rd_state,
    input  logic                              wr_en,
    input  logic [hpd_pkg::MOTOR_IDX_W-1:0]   wr_index,
    input  hpd_pkg::motor_state_t             wr_state
);

    hpd_pkg::motor_state_t state_reg [hpd_pkg::NUM_MOTORS];

    // Per-motor state, one read-modify-write per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < hpd_pkg::NUM_MOTORS; m++)
            begin
                state_reg[m].drive        <= hpd_pkg::DRIVE_STOP;
                state_reg[m].open_lim     <= hpd_pkg::RST_DEFAULT_OPEN;
                state_reg[m].close_lim    <= hpd_pkg::RST_ZERO_POINT;
                state_reg[m].settle_armed <= 1'b0;
                state_reg[m].settle_start <= '0;
                state_reg[m].stall_ref    <= '0;
            end
        end
        else if (wr_en)
        begin
            state_reg[wr_index] <= wr_state;
        end
    end

    assign rd_state = state_reg[rd_index];

endmodule

// ===== rtl/core/hpd_step.sv =====
module hpd_step (
    input  hpd_pkg::item_t         item,
    input  hpd_pkg::cfg_t          cfg,
    input  hpd_pkg::motor_state_t  cur,
    output hpd_pkg::motor_state_t  nxt,
    output logic                   state_we,
    output hpd_pkg::result_t       result
);

    logic                              id_ok;
    logic                              jack_near;
    logic                              cw;
    logic                              cv;
    logic                              zreq;
    logic                              ret;
    logic [hpd_pkg::TIME_W:0]          settle_end;

    assign id_ok      = (32'(item.motor_id) < 32'(hpd_pkg::NUM_MOTORS));
    assign jack_near  = hpd_pkg::in_band(item.jack_position, item.jack_top_limit,
                                         cfg.hysteresis);
    assign settle_end = {1'b0, cur.settle_start} + (hpd_pkg::TIME_W + 1)'(cfg.settle_time);

    // Next motor state and the flags of this tick.
    always_comb
    begin
        nxt  = cur;
        cw   = 1'b0;
        cv   = 1'b0;
        zreq = 1'b0;
        ret  = 1'b0;
        unique case (item.mode)
            hpd_pkg::MODE_RUN:
            begin
                unique case (item.setting_status)
                    hpd_pkg::STATUS_COMPLETED:
                    begin
                        if (item.down_request)
                        begin
                            nxt.drive = hpd_pkg::steer(item.motor_position, cur.open_lim,
                                                       cfg.hysteresis);
                        end
                        else if (item.up_request)
                        begin
                            if (jack_near)
                            begin
                                nxt.drive = hpd_pkg::steer(item.motor_position,
                                                           cur.close_lim, cfg.hysteresis);
                            end
                        end
                        else
                        begin
                            nxt.drive = hpd_pkg::DRIVE_STOP;
                        end
                    end
                    hpd_pkg::STATUS_JACK_UP:
                    begin
                        nxt.settle_armed = 1'b0;
                        if (jack_near)
                        begin
                            if (item.down_request)
                            begin
                                nxt.drive = hpd_pkg::DRIVE_UP;
                            end
                            else if (item.up_request)
                            begin
                                nxt.drive = hpd_pkg::DRIVE_DOWN;
                            end
                            else
                            begin
                                nxt.drive     = hpd_pkg::DRIVE_STOP;
                                zreq          = 1'b1;
                                nxt.close_lim = cfg.zero_pos;
                                nxt.open_lim  = cfg.default_open;
                            end
                        end
                    end
                    default:
                    begin
                        nxt.drive        = hpd_pkg::DRIVE_STOP;
                        nxt.settle_armed = 1'b0;
                    end
                endcase
            end
            hpd_pkg::MODE_LEARN:
            begin
                // Learn the open limit once the position has settled.
                if (!cur.settle_armed)
                begin
                    nxt.settle_armed = 1'b1;
                    nxt.settle_start = item.time_tenths;
                    nxt.stall_ref    = item.motor_position;
                end
                else if ({1'b0, item.time_tenths} > settle_end)
                begin
                    nxt.settle_armed = 1'b0;
                    if (item.motor_position == cur.stall_ref)
                    begin
                        nxt.open_lim = item.motor_position;
                        cw           = 1'b1;
                        cv           = 1'b1;
                    end
                end
                if (jack_near)
                begin
                    if (item.down_request)
                    begin
                        nxt.drive = hpd_pkg::DRIVE_UP;
                        cw        = 1'b1;
                        cv        = 1'b0;
                    end
                    else if (item.up_request)
                    begin
                        nxt.drive = hpd_pkg::DRIVE_DOWN;
                        cw        = 1'b1;
                        cv        = 1'b0;
                    end
                    else
                    begin
                        nxt.drive = hpd_pkg::DRIVE_STOP;
                    end
                end
            end
            hpd_pkg::MODE_JACK_SET_A, hpd_pkg::MODE_JACK_SET_B, hpd_pkg::MODE_JACK_SET_C:
            begin
                nxt.drive = hpd_pkg::DRIVE_STOP;
            end
            default:
            begin
                ret = 1'b1;
            end
        endcase
    end

    assign state_we = id_ok;

    // Result fields; a motor beyond the supported count reports all zeros.
    always_comb
    begin
        result = '0;
        if (id_ok)
        begin
            result.drive_up              = nxt.drive[0];
            result.drive_down            = nxt.drive[1];
            result.completed_write       = cw;
            result.completed_value       = cv;
            result.zero_position_request = zreq;
            result.return_to_running     = ret;
            result.open_limit_now        = nxt.open_lim;
        end
    end

endmodule

// ===== rtl/core/hysteresis_position_drive_top.sv =====
// Registers: the input register takes an item when it is accepted, and the result
// register takes its result when the input stage advances.
// Throughput: one item per cycle while the result side does not stall; each item's
// motor state is read, updated and written back between the two registers.
// Reset: asynchronous, active low; clears both stages, restores the registers to
// their defaults and sets every motor's pins low with default limits.
module hysteresis_position_drive_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration port
    input  logic                               cfg_write,
    input  logic [hpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hpd_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // mode[2:0], setting_status[4:3], down_request[5], up_request[6],
    // motor_position[22:7], jack_position[38:23], jack_top_limit[54:39],
    // time_tenths[86:55], zero pad[87]
    input  logic [hpd_pkg::IN_DATA_W-1:0]      s_tdata,
    // motor_id[0]
    input  logic                               s_tuser,
    // Result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // drive_up[0], drive_down[1], completed_write[2], completed_value[3],
    // zero_position_request[4], return_to_running[5], open_limit_now[21:6],
    // zero pad[23:22]
    output logic [hpd_pkg::OUT_DATA_W-1:0]     m_tdata
);

    hpd_pkg::cfg_t          cfg_reg;
    logic                   in_valid_reg;
    hpd_pkg::item_t         in_item_reg;
    hpd_pkg::item_t         in_item_next;
    logic                   out_valid_reg;
    hpd_pkg::result_t       out_result_reg;
    logic                   advance;
    logic                   state_we;
    hpd_pkg::motor_state_t  cur_state;
    hpd_pkg::motor_state_t  nxt_state;
    hpd_pkg::result_t       step_result;
    logic [hpd_pkg::MOTOR_IDX_W-1:0] motor_index;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hysteresis   <= hpd_pkg::RST_HYSTERESIS;
            cfg_reg.zero_pos     <= hpd_pkg::RST_ZERO_POINT;
            cfg_reg.default_open <= hpd_pkg::RST_DEFAULT_OPEN;
            cfg_reg.settle_time  <= hpd_pkg::RST_SETTLE_TIME;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hpd_pkg::CFG_HYSTERESIS:   cfg_reg.hysteresis   <= cfg_data;
                hpd_pkg::CFG_ZERO_POINT:   cfg_reg.zero_pos     <= cfg_data;
                hpd_pkg::CFG_DEFAULT_OPEN: cfg_reg.default_open <= cfg_data;
                hpd_pkg::CFG_SETTLE_TIME:  cfg_reg.settle_time  <= cfg_data[hpd_pkg::SETTLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input stage moves on whenever the result register is empty or being taken.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Unpack an incoming item.
    always_comb
    begin
        in_item_next.motor_id       = s_tuser;
        in_item_next.mode           = s_tdata[2:0];
        in_item_next.setting_status = s_tdata[4:3];
        in_item_next.down_request   = s_tdata[5];
        in_item_next.up_request     = s_tdata[6];
        in_item_next.motor_position = s_tdata[22:7];
        in_item_next.jack_position  = s_tdata[38:23];
        in_item_next.jack_top_limit = s_tdata[54:39];
        in_item_next.time_tenths    = s_tdata[86:55];
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg <= in_item_next;
        end
    end

    assign motor_index = hpd_pkg::MOTOR_IDX_W'(in_item_reg.motor_id);

    hpd_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_index (motor_index),
        .rd_state (cur_state),
        .wr_en    (advance && state_we),
        .wr_index (motor_index),
        .wr_state (nxt_state)
    );

    hpd_step u_step (
        .item     (in_item_reg),
        .cfg      (cfg_reg),
        .cur      (cur_state),
        .nxt      (nxt_state),
        .state_we (state_we),
        .result   (step_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_result_reg.open_limit_now,
                       out_result_reg.return_to_running,
                       out_result_reg.zero_position_request,
                       out_result_reg.completed_value,
                       out_result_reg.completed_write,
                       out_result_reg.drive_down,
                       out_result_reg.drive_up};

endmodule

// ===== rtl/core/hpd_checker.sv =====
module hpd_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [hpd_pkg::OUT_DATA_W-1:0]     m_tdata
);

    // A result that is not taken stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn before it was taken");

    // A stalled result keeps its value.
    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("stalled result changed");

    // The motor is never driven up and down at once.
    a_pins_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("both drive pins high");

    // A completed value is only reported together with its write strobe.
    a_value_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> m_tdata[2])
        else $error("completed value without write");

    // A re-zero request comes with the pins stopped and a valid mode.
    a_zero_stops: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> !m_tdata[0] && !m_tdata[1] && !m_tdata[5])
        else $error("re-zero request while driving or in an invalid mode");

endmodule

bind hysteresis_position_drive_top hpd_checker u_hpd_checker (.*);

// ===== dv/hysteresis_position_drive_top_test.sv =====
module hysteresis_position_drive_top_test;
    import hpd_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int PHASES           = 8;
    localparam int RANDOM_PER_PHASE = 230;
    localparam int POS_MAX          = 65535;

    // Codes the package leaves unnamed.
    localparam logic [1:0] STATUS_OTHER    = 2'd2;
    localparam logic [1:0] STATUS_SPARE    = 2'd3;
    localparam logic [2:0] MODE_INVALID_LO = 3'd5;
    localparam logic [2:0] MODE_INVALID_HI = 3'd7;

    // Kinds of random bursts.
    localparam int MIXED_BURST = 0;
    localparam int LEARN_BURST = 1;
    localparam int RUN_BURST   = 2;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;

    // Register copies used by the predictor.
    logic [POS_W-1:0]    hyst_reg;
    logic [POS_W-1:0]    zero_reg;
    logic [POS_W-1:0]    open_default_reg;
    logic [SETTLE_W-1:0] settle_reg;

    // Per-motor state of the predictor.
    logic [1:0]        pin_state [NUM_MOTORS];
    logic [POS_W-1:0]  open_lim  [NUM_MOTORS];
    logic [POS_W-1:0]  close_lim [NUM_MOTORS];
    logic              armed     [NUM_MOTORS];
    logic [TIME_W-1:0] armed_at  [NUM_MOTORS];
    logic [POS_W-1:0]  stall_pos [NUM_MOTORS];

    item_t   tick_queue[$];
    result_t due_results[$];
    item_t   offered;

    // Stimulus generator state.
    int                burst_kind = MIXED_BURST;
    int                burst_left = 0;
    logic [POS_W-1:0]  last_pos [NUM_MOTORS];
    logic [TIME_W-1:0] clock_now = '0;

    // Handshake bookkeeping.
    logic in_taken   = 1'b0;
    logic out_taken  = 1'b0;
    logic send_idle  = 1'b1;
    logic recv_idle  = 1'b1;
    int   in_gap     = 0;
    int   out_gap    = 0;
    int   hold_left  = 0;
    int   taken_count = 0;
    int   n_errors   = 0;
    int   cycle_count = 0;

    hysteresis_position_drive_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 clk = ~clk;

    // Drive direction that brings a position into the dead band of a target.
    function automatic logic [1:0] chase(input int pos, input int target, input int h);
        if (pos < target - h)
        begin
            chase = DRIVE_UP;
        end
        else if (pos > target + h)
        begin
            chase = DRIVE_DOWN;
        end
        else
        begin
            chase = DRIVE_STOP;
        end
    endfunction

    // Applies one control tick to the predicted motor state and returns its result.
    function automatic result_t drive_step(input item_t it);
        result_t r;
        int      m;
        int      pos;
        int      jack;
        int      top;
        int      h;
        logic    near;
        r    = '0;
        m    = it.motor_id;
        pos  = it.motor_position;
        jack = it.jack_position;
        top  = it.jack_top_limit;
        h    = hyst_reg;
        near = (jack > top - h) && (jack < top + h);
        if (it.mode == MODE_RUN)
        begin
            if (it.setting_status == STATUS_COMPLETED)
            begin
                if (it.down_request)
                begin
                    pin_state[m] = chase(pos, open_lim[m], h);
                end
                else if (it.up_request)
                begin
                    // Closing is only allowed while the jack sits near its top limit.
                    if (near)
                    begin
                        pin_state[m] = chase(pos, close_lim[m], h);
                    end
                end
                else
                begin
                    pin_state[m] = DRIVE_STOP;
                end
            end
            else if (it.setting_status == STATUS_JACK_UP)
            begin
                armed[m] = 1'b0;
                if (near)
                begin
                    if (it.down_request)
                    begin
                        pin_state[m] = DRIVE_UP;
                    end
                    else if (it.up_request)
                    begin
                        pin_state[m] = DRIVE_DOWN;
                    end
                    else
                    begin
                        // No jog request: re-zero the limits.
                        pin_state[m]           = DRIVE_STOP;
                        r.zero_position_request = 1'b1;
                        close_lim[m]           = zero_reg;
                        open_lim[m]            = open_default_reg;
                    end
                end
            end
            else
            begin
                pin_state[m] = DRIVE_STOP;
                armed[m]     = 1'b0;
            end
        end
        else if (it.mode == MODE_LEARN)
        begin
            if (!armed[m])
            begin
                armed[m]     = 1'b1;
                armed_at[m]  = it.time_tenths;
                stall_pos[m] = it.motor_position;
            end
            else if ({1'b0, it.time_tenths} > {1'b0, armed_at[m]} + {25'd0, settle_reg})
            begin
                // Settle time is over; learn the limit only if nothing moved.
                armed[m] = 1'b0;
                if (it.motor_position == stall_pos[m])
                begin
                    open_lim[m]         = it.motor_position;
                    r.completed_write = 1'b1;
                    r.completed_value = 1'b1;
                end
            end
            if (near)
            begin
                if (it.down_request)
                begin
                    pin_state[m]        = DRIVE_UP;
                    r.completed_write = 1'b1;
                    r.completed_value = 1'b0;
                end
                else if (it.up_request)
                begin
                    pin_state[m]        = DRIVE_DOWN;
                    r.completed_write = 1'b1;
                    r.completed_value = 1'b0;
                end
                else
                begin
                    pin_state[m] = DRIVE_STOP;
                end
            end
        end
        else if (it.mode <= MODE_JACK_SET_C)
        begin
            pin_state[m] = DRIVE_STOP;
        end
        else
        begin
            r.return_to_running = 1'b1;
        end
        r.drive_up       = pin_state[m][0];
        r.drive_down     = pin_state[m][1];
        r.open_limit_now = open_lim[m];
        return r;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_tick(input item_t it);
        pack_tick = {1'b0, it.time_tenths, it.jack_top_limit, it.jack_position,
                     it.motor_position, it.up_request, it.down_request,
                     it.setting_status, it.mode};
    endfunction

    function automatic item_t tick(input logic id, input logic [2:0] mode,
                                   input logic [1:0] status, input logic dn,
                                   input logic up, input logic [POS_W-1:0] pos,
                                   input logic [POS_W-1:0] jack,
                                   input logic [POS_W-1:0] top,
                                   input logic [TIME_W-1:0] t);
        tick.motor_id       = id;
        tick.mode           = mode;
        tick.setting_status = status;
        tick.down_request   = dn;
        tick.up_request     = up;
        tick.motor_position = pos;
        tick.jack_position  = jack;
        tick.jack_top_limit = top;
        tick.time_tenths    = t;
    endfunction

    function automatic logic [POS_W-1:0] clamp16(input int v);
        if (v < 0)
        begin
            clamp16 = '0;
        end
        else if (v > POS_MAX)
        begin
            clamp16 = POS_MAX;
        end
        else
        begin
            clamp16 = v;
        end
    endfunction

    // Random tick, shaped by bursts of learning or run sequences.
    function automatic item_t random_tick();
        item_t it;
        int    h;
        int    roll;
        int    keep;
        int    anchor;
        int    off;
        int    top;
        if (burst_left == 0)
        begin
            burst_kind = $urandom_range(0, 2);
            burst_left = $urandom_range(10, 40);
        end
        burst_left--;
        h           = hyst_reg;
        it.motor_id = $urandom_range(0, 1);

        // Mode.
        roll = $urandom_range(0, 99);
        if (burst_kind == LEARN_BURST)
        begin
            it.mode = (roll < 90) ? MODE_LEARN : MODE_RUN;
        end
        else if (burst_kind == RUN_BURST)
        begin
            it.mode = (roll < 90) ? MODE_RUN : MODE_LEARN;
        end
        else if (roll < 40)
        begin
            it.mode = MODE_RUN;
        end
        else if (roll < 65)
        begin
            it.mode = MODE_LEARN;
        end
        else if (roll < 82)
        begin
            it.mode = $urandom_range(MODE_JACK_SET_A, MODE_JACK_SET_C);
        end
        else
        begin
            it.mode = $urandom_range(MODE_INVALID_LO, MODE_INVALID_HI);
        end

        // Setting status.
        roll = $urandom_range(0, 99);
        if (burst_kind == RUN_BURST && roll < 70)
        begin
            it.setting_status = STATUS_COMPLETED;
        end
        else if (roll < 55)
        begin
            it.setting_status = STATUS_COMPLETED;
        end
        else if (roll < 85)
        begin
            it.setting_status = STATUS_JACK_UP;
        end
        else if (roll < 95)
        begin
            it.setting_status = STATUS_OTHER;
        end
        else
        begin
            it.setting_status = STATUS_SPARE;
        end

        // Requests are rare while learning so the position can settle.
        if (burst_kind == LEARN_BURST && $urandom_range(0, 9) != 0)
        begin
            {it.down_request, it.up_request} = 2'b00;
        end
        else
        begin
            {it.down_request, it.up_request} = $urandom_range(0, 3);
        end

        // Jack mostly around its top limit, including the band edges.
        top               = $urandom_range(0, POS_MAX);
        it.jack_top_limit = top;
        if ($urandom_range(0, 9) < 8)
        begin
            it.jack_position = clamp16(top + $urandom_range(0, 2 * h + 2) - h - 1);
        end
        else
        begin
            it.jack_position = $urandom_range(0, POS_MAX);
        end

        // Position: held still, near a band edge of a limit, extreme or random.
        keep = (burst_kind == LEARN_BURST) ? 85 : 35;
        roll = $urandom_range(0, 99);
        if (roll < keep)
        begin
            it.motor_position = last_pos[it.motor_id];
        end
        else if (roll < keep + 30)
        begin
            anchor = $urandom_range(0, 1) ? open_lim[it.motor_id] : close_lim[it.motor_id];
            off    = ($urandom_range(0, 1) ? h : -h) + $urandom_range(0, 2) - 1;
            it.motor_position = clamp16(anchor + off);
        end
        else if (roll < keep + 38)
        begin
            it.motor_position = $urandom_range(0, 1) ? POS_MAX : 0;
        end
        else
        begin
            it.motor_position = $urandom_range(0, POS_MAX);
        end
        last_pos[it.motor_id] = it.motor_position;

        // Time mostly creeps forward, with occasional jumps anywhere.
        if ($urandom_range(0, 49) == 0)
        begin
            clock_now = $urandom;
        end
        else
        begin
            clock_now = clock_now + $urandom_range(0, 4);
        end
        it.time_tenths = clock_now;
        return it;
    endfunction

    // Writes all four registers while the block is idle.
    task automatic configure(input logic [POS_W-1:0] h, input logic [POS_W-1:0] z,
                             input logic [POS_W-1:0] o, input logic [SETTLE_W-1:0] s);
        hyst_reg         = h;
        zero_reg         = z;
        open_default_reg = o;
        settle_reg       = s;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_HYSTERESIS;
        cfg_data  <= h;
        @(negedge clk);
        cfg_index <= CFG_ZERO_POINT;
        cfg_data  <= z;
        @(negedge clk);
        cfg_index <= CFG_DEFAULT_OPEN;
        cfg_data  <= o;
        @(negedge clk);
        cfg_index <= CFG_SETTLE_TIME;
        cfg_data  <= {8'd0, s};
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_idle();
        while (tick_queue.size() != 0 || s_tvalid || due_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            n_errors++;
        end
    endtask

    // Sender: presents queued items at the falling edge with random gaps.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                s_tvalid <= 1'b0;
            end
            else if (tick_queue.size() != 0)
            begin
                offered = tick_queue.pop_front();
                s_tdata  <= pack_tick(offered);
                s_tuser  <= offered.motor_id;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                begin
                    send_idle = !send_idle;
                end
                in_gap = send_idle ? $urandom_range(0, 3) : 0;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Each accepted item updates the prediction.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            due_results.push_back(drive_step(offered));
            in_taken = 1'b1;
        end
    end

    // Receiver: random stalls per result, and a long hold-off now and then
    // so that the block fills up and stalls its input.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (out_taken)
            begin
                out_taken = 1'b0;
                taken_count++;
                if (taken_count % 700 == 300)
                begin
                    hold_left = 120;
                end
                if ($urandom_range(0, 49) == 0)
                begin
                    recv_idle = !recv_idle;
                end
                out_gap = recv_idle ? $urandom_range(0, 3) : 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            out_taken = 1'b1;
            if (due_results.size() == 0)
            begin
                $error("result item with none expected: %h", m_tdata);
                n_errors++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("drive_up", want.drive_up, m_tdata[0]);
                check_field("drive_down", want.drive_down, m_tdata[1]);
                check_field("completed_write", want.completed_write, m_tdata[2]);
                check_field("completed_value", want.completed_value, m_tdata[3]);
                check_field("zero_position_request", want.zero_position_request,
                            m_tdata[4]);
                check_field("return_to_running", want.return_to_running, m_tdata[5]);
                check_field("open_limit_now", want.open_limit_now, m_tdata[21:6]);
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("hysteresis_position_drive_top verification failed");
            $finish;
        end
    end

    initial
    begin
        int m;
        int phase;
        int md;
        hyst_reg         = RST_HYSTERESIS;
        zero_reg         = RST_ZERO_POINT;
        open_default_reg = RST_DEFAULT_OPEN;
        settle_reg       = RST_SETTLE_TIME;
        for (m = 0; m < NUM_MOTORS; m++)
        begin
            pin_state[m] = DRIVE_STOP;
            open_lim[m]  = RST_DEFAULT_OPEN;
            close_lim[m] = RST_ZERO_POINT;
            armed[m]     = 1'b0;
            armed_at[m]  = '0;
            stall_pos[m] = '0;
            last_pos[m]  = '0;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed ticks at the reset settings: band edges of both limits,
        // jack band edges, both requests, re-zero, learning with and without
        // motion, learning together with a drive request, no wrap of time.
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 1, 0, 0, 0, POS_MAX, 0));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 1, 0, 49950, 0, 0, 1));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 1, 0, 49949, 0, 0, 2));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 1, 0, 50051, 0, 0, 3));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 1, 0, POS_MAX, 0, 0, 4));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 0, 1, 10, 1000, 1000, 5));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 0, 1, POS_MAX,
                                  1050, 1000, 6));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 0, 1, 50, 951, 1000, 7));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 0, 1, 51, 951, 1000, 8));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 1, 1, 0, 0, 0, 9));
        tick_queue.push_back(tick(0, MODE_RUN, STATUS_COMPLETED, 0, 0, 0, 0, 0, 10));
        tick_queue.push_back(tick(1, MODE_RUN, STATUS_JACK_UP, 1, 0, 300, 0, 0, 11));
        tick_queue.push_back(tick(1, MODE_RUN, STATUS_JACK_UP, 0, 1, 300, 0, 0, 12));
        tick_queue.push_back(tick(1, MODE_RUN, STATUS_JACK_UP, 0, 0, 300, POS_MAX, 0, 13));
        tick_queue.push_back(tick(1, MODE_RUN, STATUS_JACK_UP, 0, 0, 300, 0, 0, 14));
        tick_queue.push_back(tick(1, MODE_RUN, STATUS_OTHER, 1, 0, 300, 0, 0, 15));
        tick_queue.push_back(tick(1, MODE_RUN, STATUS_SPARE, 1, 0, 300, 0, 0, 16));
        tick_queue.push_back(tick(1, MODE_LEARN, STATUS_OTHER, 0, 0, 1234, POS_MAX, 0, 100));
        tick_queue.push_back(tick(1, MODE_LEARN, STATUS_OTHER, 0, 0, 1234, POS_MAX, 0, 131));
        tick_queue.push_back(tick(1, MODE_LEARN, STATUS_OTHER, 0, 0, 777, 0, 0, 200));
        tick_queue.push_back(tick(1, MODE_LEARN, STATUS_OTHER, 1, 0, 777, 0, 0, 231));
        tick_queue.push_back(tick(1, MODE_LEARN, STATUS_OTHER, 0, 0, 5, 0, 0, 300));
        tick_queue.push_back(tick(1, MODE_LEARN, STATUS_OTHER, 0, 0, 6, 0, 0, 400));
        tick_queue.push_back(tick(0, MODE_LEARN, STATUS_OTHER, 0, 0, 9, 0, 0, 32'hFFFF_FFF0));
        tick_queue.push_back(tick(0, MODE_LEARN, STATUS_OTHER, 0, 0, 9, 0, 0, 32'hFFFF_FFFF));
        for (md = MODE_JACK_SET_A; md <= MODE_INVALID_HI; md++)
        begin
            tick_queue.push_back(tick(0, md, STATUS_COMPLETED, 1, 0, 0, 0, 0, 500));
        end

        // Random phases, each at its own register setting.
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            if (phase == 1)
            begin
                configure(16'd0, 16'd0, 16'hFFFF, 8'd0);
            end
            else if (phase == 2)
            begin
                configure(16'hFFFF, 16'hFFFF, 16'd0, 8'hFF);
            end
            else if (phase == 3)
            begin
                configure(16'd1, 16'd100, 16'd40000, 8'd1);
            end
            else if (phase > 3)
            begin
                configure($urandom_range(0, 300), $urandom, $urandom, $urandom_range(0, 40));
            end
            repeat (RANDOM_PER_PHASE) tick_queue.push_back(random_tick());
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $error("%0d result items never arrived", due_results.size());
            n_errors++;
        end
        if (n_errors == 0)
        begin
            $display("hysteresis_position_drive_top verification clean");
        end
        else
        begin
            $display("hysteresis_position_drive_top verification failed");
        end
        $finish;
    end

endmodule
